// ===== rtl/tnsl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tnsl_pkg
// shared types, constants and helpers of the top-n score list
// ---------------------------------------------------------------------------
package tnsl_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // fixed field widths
   localparam int CMD_W       = 2;
   localparam int SCORE_W     = 32;
   localparam int KEY_W       = 32;
   localparam int TAG_W       = 32;
   localparam int RANK_W      = 4;
   localparam int CODE_W      = 2;
   localparam int POS_W       = 4;
   localparam int LIST_CNT_W  = 5;
   localparam int TOP_N_W     = 5;
   localparam logic [TOP_N_W-1:0] TOP_N_RESET = TOP_N_W'(5);

   typedef enum logic [CMD_W-1:0] {
      CMD_OFFER = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CODE_W-1:0] {
      RES_REJECTED = 2'd0,
      RES_INSERTED = 2'd1,
      RES_REPLACED = 2'd2,
      RES_DROPPED  = 2'd3
   } code_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic        [KEY_W-1:0]   key;
      logic        [TAG_W-1:0]   tag;
   } entry_type;

   // compare request broadcast to all cells on the accept edge
   typedef struct packed {
      logic                      en;
      logic signed [SCORE_W-1:0] score;
      logic        [KEY_W-1:0]   key;
   } cmp_type;

   // update request broadcast to all cells in the apply cycle
   typedef struct packed {
      logic write;    // place the new entry and shift the tail
      logic bounded;  // shift stops at the first lower duplicate
   } apply_type;

   // top_n saturated to 1..MAX_ENTRIES
   function automatic logic [CNT_W-1:0] eff_limit(input logic [TOP_N_W-1:0] top_n);
      int lim;
      lim = int'(top_n);
      if (lim < 1) lim = 1;
      if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
      return CNT_W'(lim);
   endfunction

endpackage

// ===== rtl/tnsl_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tnsl_cell
// one rank of the sorted list: holds an entry, compares, shifts from neighbor
// ---------------------------------------------------------------------------
module tnsl_cell (
   input  logic                clock,
   input  logic                reset,
   input  tnsl_pkg::cmp_type   cmp,
   input  logic                slot_valid,
   input  tnsl_pkg::apply_type apply,
   input  tnsl_pkg::entry_type new_entry,
   input  tnsl_pkg::entry_type prev_entry,
   input  logic                prev_before,
   input  logic                prev_seen,
   output tnsl_pkg::entry_type entry,
   output logic                ahead,
   output logic                match,
   output logic                seen
);
   import tnsl_pkg::*;

   entry_type entry_ff, entry_in;
   logic      before_ff, match_ff;
   logic      at_pos, after_pos, in_span;

   always_comb begin
      at_pos    = !before_ff && prev_before;
      after_pos = !prev_before;
      in_span   = !apply.bounded || !prev_seen;
      entry_in  = entry_ff;
      priority if (apply.write && at_pos) begin
         entry_in = new_entry;
      end else if (apply.write && after_pos && in_span) begin
         entry_in = prev_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // ahead: stored entry keeps its rank ahead of the newcomer
   always_ff @(posedge clock) begin
      if (reset) begin
         before_ff <= 1'b0;
         match_ff  <= 1'b0;
      end else if (cmp.en) begin
         before_ff <= slot_valid && !($signed(cmp.score) > $signed(entry_ff.score));
         match_ff  <= slot_valid && (entry_ff.key == cmp.key);
      end
   end

   assign entry  = entry_ff;
   assign ahead  = before_ff;
   assign match  = match_ff;
   assign seen   = prev_seen | match_ff;

endmodule

// ===== rtl/top_n_score_list_with_dedup_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// top_n_score_list_with_dedup_unit
// sorted top-n candidate list with duplicate key removal
// ---------------------------------------------------------------------------
// usage
//   request transaction: req_* fields are taken at a clock edge with start
//   high and busy low. req_cmd selects offer, read by rank or clear.
//   each transaction gives one response on rsp_* for exactly one cycle,
//   marked by rsp_strobe; the receiver cannot stall it.
//   timing: in the cycle after the accept edge busy is high and the cells
//   apply the update; the response shows in the following cycle, when busy
//   is low again and the next request can be taken. so a new request is not
//   taken while one is in flight: the cells compare at the accept edge and
//   shift at the edge that ends the apply cycle.
//   csr_we/csr_wdata write top_n (limit); a lower limit trims the list tail.
//   write it only while no transaction is in flight.
//   reset: list empty, top_n = 5, no response pending; entry contents stay
//   undefined until written and are never shown.
// ---------------------------------------------------------------------------
module top_n_score_list_with_dedup_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [tnsl_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [tnsl_pkg::SCORE_W-1:0]   req_score,
   input  logic [tnsl_pkg::KEY_W-1:0]            req_peptide_key,
   input  logic [tnsl_pkg::TAG_W-1:0]            req_record_tag,
   input  logic [tnsl_pkg::RANK_W-1:0]           req_read_rank,
   output logic                                  rsp_strobe,
   output logic [tnsl_pkg::CODE_W-1:0]           rsp_result_code,
   output logic [tnsl_pkg::POS_W-1:0]            rsp_position,
   output logic [tnsl_pkg::LIST_CNT_W-1:0]       rsp_list_count,
   output logic                                  rsp_read_valid,
   output logic signed [tnsl_pkg::SCORE_W-1:0]   rsp_read_score,
   output logic [tnsl_pkg::KEY_W-1:0]            rsp_read_key,
   output logic [tnsl_pkg::TAG_W-1:0]            rsp_read_tag,
   input  logic                                  csr_we,
   input  logic [tnsl_pkg::TOP_N_W-1:0]          csr_wdata
);
   import tnsl_pkg::*;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOP_N_W-1:0] top_n_ff;
   logic [CNT_W-1:0]   lim, lim_next;

   // held request payload
   cmd_type            cmd_ff;
   entry_type          held_ff;
   logic [RANK_W-1:0]  rank_ff;

   // response registers
   logic               strobe_ff;
   code_type           code_ff, code_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   rcnt_ff;
   logic               rvalid_ff, rvalid_in;
   entry_type          rentry_ff, rentry_in;

   // cell chain
   cmp_type                cmp;
   apply_type              apply;
   logic [MAX_ENTRIES-1:0] slot_valid;
   entry_type              cell_entry [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] before_vec, match_vec, seen_vec;
   logic [MAX_ENTRIES-1:0] before_inc;

   // decisions from the registered compare flags
   logic [CNT_W-1:0]   place;
   logic               placed, any_match, better_dup;
   logic [CNT_W:0]     count_sel;

   logic accept;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_APPLY);
   assign lim    = eff_limit(top_n_ff);

   // compare at the accept edge straight from the request ports
   assign cmp.en    = accept;
   assign cmp.score = req_score;
   assign cmp.key   = req_peptide_key;

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         slot_valid[i] = (CNT_W'(i) < count_ff);
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            // head cell: nothing ranks above it
            tnsl_cell u_cell (
               .clock       (clock),
               .reset       (reset),
               .cmp         (cmp),
               .slot_valid  (slot_valid[gi]),
               .apply       (apply),
               .new_entry   (held_ff),
               .prev_entry  (held_ff),
               .prev_before (1'b1),
               .prev_seen   (1'b0),
               .entry       (cell_entry[gi]),
               .ahead       (before_vec[gi]),
               .match       (match_vec[gi]),
               .seen        (seen_vec[gi])
            );
         end else begin : g_body
            tnsl_cell u_cell (
               .clock       (clock),
               .reset       (reset),
               .cmp         (cmp),
               .slot_valid  (slot_valid[gi]),
               .apply       (apply),
               .new_entry   (held_ff),
               .prev_entry  (cell_entry[gi-1]),
               .prev_before (before_vec[gi-1]),
               .prev_seen   (seen_vec[gi-1]),
               .entry       (cell_entry[gi]),
               .ahead       (before_vec[gi]),
               .match       (match_vec[gi]),
               .seen        (seen_vec[gi])
            );
         end
      end
   endgenerate

   // placement rank: first cell that does not stay ahead of the newcomer
   always_comb begin
      place = CNT_W'(MAX_ENTRIES);
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!before_vec[i]) place = CNT_W'(i);
      end
   end

   assign placed     = (place < count_ff) || (count_ff < lim);
   assign any_match  = |match_vec;
   assign better_dup = |(match_vec & before_vec);
   assign before_inc = before_vec + MAX_ENTRIES'(1);

   // next state, list update and response
   always_comb begin
      state_in      = state_ff;
      apply.write   = 1'b0;
      apply.bounded = 1'b0;
      count_sel     = {1'b0, count_ff};
      code_in       = RES_REJECTED;
      pos_in        = '0;
      rvalid_in     = 1'b0;
      rentry_in     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
            unique case (cmd_ff)
               CMD_OFFER: begin
                  if (placed) begin
                     pos_in = POS_W'(place);
                     priority if (better_dup) begin
                        // a higher-ranked entry shares the key: list unchanged
                        code_in = RES_DROPPED;
                     end else if (any_match) begin
                        // lower duplicate leaves, count stays
                        code_in       = RES_REPLACED;
                        apply.write   = 1'b1;
                        apply.bounded = 1'b1;
                     end else begin
                        code_in     = RES_INSERTED;
                        apply.write = 1'b1;
                        count_sel   = {1'b0, count_ff} + (CNT_W + 1)'(1);
                     end
                  end
               end
               CMD_READ: begin
                  if ((CNT_W + RANK_W)'(rank_ff) < (CNT_W + RANK_W)'(count_ff)) begin
                     rvalid_in = 1'b1;
                     for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if ((CNT_W + RANK_W)'(rank_ff) == (CNT_W + RANK_W)'(i)) begin
                           rentry_in = cell_entry[i];
                        end
                     end
                  end
               end
               CMD_CLEAR: begin
                  count_sel = '0;
               end
               CMD_NONE: begin
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // tail discard, also against a freshly written limit
      lim_next = csr_we ? eff_limit(csr_wdata) : lim;
      if (count_sel > {1'b0, lim_next}) begin
         count_in = lim_next;
      end else begin
         count_in = count_sel[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         top_n_ff  <= TOP_N_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= (state_ff == ST_APPLY);
         if (csr_we) top_n_ff <= csr_wdata;
      end
   end

   // request payload held for the apply cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= cmd_type'(req_cmd);
         held_ff.score <= req_score;
         held_ff.key   <= req_peptide_key;
         held_ff.tag   <= req_record_tag;
         rank_ff       <= req_read_rank;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_APPLY) begin
         code_ff   <= code_in;
         pos_ff    <= pos_in;
         rcnt_ff   <= count_in;
         rvalid_ff <= rvalid_in;
         rentry_ff <= rentry_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_code = code_ff;
   assign rsp_position    = pos_ff;
   assign rsp_list_count  = LIST_CNT_W'(rcnt_ff);
   assign rsp_read_valid  = rvalid_ff;
   assign rsp_read_score  = rentry_ff.score;
   assign rsp_read_key    = rentry_ff.key;
   assign rsp_read_tag    = rentry_ff.tag;

   // list never holds more than the limit
   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lim)
      else $error("entry count above limit");

   // after each apply cycle busy is low again and the response strobe is high
   a_apply_then_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_strobe))
      else $error("apply cycle not followed by a response");

   // cells ahead of the newcomer form a prefix of the list
   a_before_prefix: assert property (@(posedge clock) disable iff (reset)
      busy |-> ((before_vec & before_inc) == '0))
      else $error("compare flags not a prefix");

   // a candidate dropped for a better duplicate leaves the count alone
   a_drop_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (busy && cmd_ff == CMD_OFFER && placed && better_dup && !csr_we)
      |=> (count_ff == $past(count_ff)))
      else $error("dropped candidate changed the list");

   // a valid read response comes only from a non-empty list
   a_read_on_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_read_valid) |-> (rsp_list_count != '0))
      else $error("read valid on an empty list");

endmodule
